/* sv/jstb_pkg.sv */
// ----------------------------------------------------------------------------
// jstb_pkg
// Shared types and codes of the JavaScript token boundary unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jstb_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 24;

  // Token kinds as reported in token_kind.
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_NUMBER  = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_PUNCT   = 3'd4;
  localparam logic [2:0] KIND_EOF     = 3'd5;

  // Result queue depth; one byte can produce two words.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } src_word_t;

  typedef struct packed {
    logic [2:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] end_offset;
    logic [LINE_BITS-1:0]   start_line;
    logic [LINE_BITS-1:0]   start_column;
    logic [LINE_BITS-1:0]   end_line;
    logic [LINE_BITS-1:0]   end_column;
    logic                   final_token;
  } tok_word_t;

  // Words produced by one byte, in output order; count is 0, 1 or 2.
  typedef struct packed {
    tok_word_t  rec0;
    tok_word_t  rec1;
    logic [1:0] count;
  } jstb_push_t;

endpackage

`default_nettype wire

/* sv/js_lexer_token_boundary_unit.sv */
// ----------------------------------------------------------------------------
// js_lexer_token_boundary_unit
// Streaming JavaScript token boundary finder: source bytes in, token words out.
// ----------------------------------------------------------------------------
//   channel | handshake            | word
//   --------+----------------------+--------------------------------------
//   src     | src_valid/src_stall  | char_byte, last_byte
//   tok     | tok_valid/tok_stall  | kind, start/end offset, line, column
//
// One byte is taken per cycle unless the input stalls.  A byte is held in the
// input register; when the queue has room, the lexer updates its state in a
// single pass and writes zero, one or two token words into a four-word result
// queue.  A byte that closes two tokens yields two words that leave the queue
// one after the other, so the queue sets the sustained rate under such
// bursts.  The input stalls while the queue has fewer than two free words.
// Reset clears the lexer state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module js_lexer_token_boundary_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  output logic                    src_stall,
  input  wire jstb_pkg::src_word_t src_data,
  output logic                    tok_valid,
  input  wire logic               tok_stall,
  output jstb_pkg::tok_word_t     tok_data
);
  import jstb_pkg::*;

  logic       held_valid;
  src_word_t  held;
  logic       has_room;
  logic       step;
  jstb_push_t push;

  assign step      = held_valid && has_room;
  assign src_stall = held_valid && !has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!src_stall) begin
      held_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      held <= src_data;
    end
  end

  jstb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held),
    .push (push)
  );

  jstb_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (has_room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

  // The input only stalls when a byte is waiting for queue space.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> held_valid)
    else $error("input stalled with no byte held");

  // Counters only move forward, so no token ends before it starts.
  a_token_order: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_data.end_offset >= tok_data.start_offset))
    else $error("token ends before it starts");

  // An end-of-file token is empty.
  a_eof_empty: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && (tok_data.token_kind == KIND_EOF)) |->
      ((tok_data.start_offset == tok_data.end_offset) &&
       (tok_data.start_line == tok_data.end_line) &&
       (tok_data.start_column == tok_data.end_column)))
    else $error("end-of-file token is not empty");

  // A byte is only processed when the queue can absorb both of its words.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (step && has_room))
    else $error("words pushed without queue space");

endmodule

`default_nettype wire

/* sv/jstb_core.sv */
// ----------------------------------------------------------------------------
// jstb_core
// Lexer state and the single-pass next-state logic for one source byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jstb_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire jstb_pkg::src_word_t item,
  output jstb_pkg::jstb_push_t    push
);
  import jstb_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_LINE   = 3'd4;
  localparam logic [2:0] M_BLOCK  = 3'd5;
  localparam logic [2:0] M_OP     = 3'd6;

  localparam logic [1:0] R_MORE   = 2'd0;
  localparam logic [1:0] R_AFTER  = 2'd1;
  localparam logic [1:0] R_BEFORE = 2'd2;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   col;
  } pos_t;

  localparam pos_t POS_RESET = '{off: '0, line: LINE_BITS'(1), col: LINE_BITS'(1)};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_") || (c == "$");
  endfunction

  function automatic logic is_number_char(input logic [7:0] c);
    return is_digit(c) || (c == ".") || (c == "x") || (c == "X") ||
           (c == "e") || (c == "E");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_op_pair(input logic [7:0] a, input logic [7:0] b);
    return ((a == "=") && (b == "=")) || ((a == "!") && (b == "=")) ||
           ((a == "<") && (b == "=")) || ((a == ">") && (b == "=")) ||
           ((a == "&") && (b == "&")) || ((a == "|") && (b == "|")) ||
           ((a == "+") && (b == "+")) || ((a == "-") && (b == "-")) ||
           ((a == "=") && (b == ">"));
  endfunction

  // Counters stick at their all-ones value.
  function automatic pos_t advance(input pos_t p, input logic [7:0] c);
    pos_t n;
    n = p;
    if (p.off != '1) n.off = p.off + 1'b1;
    if (c == 8'h0a) begin
      if (p.line != '1) n.line = p.line + 1'b1;
      n.col = LINE_BITS'(1);
    end else if (p.col != '1) begin
      n.col = p.col + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [2:0] kind_of(input logic [2:0] m);
    logic [2:0] k;
    unique case (m)
      M_IDENT:         k = KIND_IDENT;
      M_NUMBER:        k = KIND_NUMBER;
      M_STRING:        k = KIND_STRING;
      M_LINE, M_BLOCK: k = KIND_COMMENT;
      default:         k = KIND_PUNCT;
    endcase
    return k;
  endfunction

  function automatic tok_word_t make_rec(input logic [2:0] kind, input pos_t s,
                                         input pos_t e, input logic fin);
    tok_word_t r;
    r.token_kind   = kind;
    r.start_offset = s.off;
    r.end_offset   = e.off;
    r.start_line   = s.line;
    r.start_column = s.col;
    r.end_line     = e.line;
    r.end_column   = e.col;
    r.final_token  = fin;
    return r;
  endfunction

  logic [2:0] mode;
  logic [7:0] quote_char;
  logic       escape_pending;
  logic [7:0] first_op_char;
  logic       star_seen;
  pos_t       tok_start;
  pos_t       pos;
  logic       trailing_space;

  logic [2:0] mode_next;
  logic [7:0] quote_char_next;
  logic       escape_pending_next;
  logic [7:0] first_op_char_next;
  logic       star_seen_next;
  pos_t       tok_start_next;
  pos_t       pos_next;
  logic       trailing_space_next;

  logic [7:0] c;
  logic [1:0] res;
  logic [2:0] mode_a;
  logic       busy;
  logic       taken;
  logic       emit_a;
  logic       emit_b;
  tok_word_t  rec_a;
  tok_word_t  rec_b;

  always_comb begin
    c                   = item.char_byte;
    pos_next            = advance(pos, c);
    res                 = R_MORE;
    mode_a              = mode;
    escape_pending_next = escape_pending;
    star_seen_next      = star_seen;

    // Offer the byte to the token in progress.
    unique case (mode)
      M_IDENT:  res = is_ident_char(c) ? R_MORE : R_BEFORE;
      M_NUMBER: res = is_number_char(c) ? R_MORE : R_BEFORE;
      M_STRING: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (c == 8'h5c) begin
          escape_pending_next = 1'b1;
        end else if (c == quote_char) begin
          res = R_AFTER;
        end
      end
      M_LINE:   res = (c == 8'h0a) ? R_BEFORE : R_MORE;
      M_BLOCK: begin
        if (star_seen && (c == "/")) begin
          res = R_AFTER;
        end else begin
          star_seen_next = (c == "*");
        end
      end
      M_OP: begin
        priority if ((first_op_char == "/") && (c == "/")) begin
          mode_a = M_LINE;
        end else if ((first_op_char == "/") && (c == "*")) begin
          mode_a         = M_BLOCK;
          star_seen_next = 1'b0;
        end else begin
          res = is_op_pair(first_op_char, c) ? R_AFTER : R_BEFORE;
        end
      end
      default: res = R_MORE;
    endcase

    busy   = (mode != M_IDLE);
    emit_a = busy && (res != R_MORE);
    taken  = busy && (res != R_BEFORE);
    rec_a  = make_rec(kind_of(mode), tok_start, (res == R_AFTER) ? pos_next : pos, 1'b0);

    mode_next           = emit_a ? M_IDLE : mode_a;
    quote_char_next     = quote_char;
    first_op_char_next  = first_op_char;
    tok_start_next      = tok_start;
    trailing_space_next = trailing_space;

    // A byte not taken by a token starts a new one, or is skipped whitespace.
    if (!taken) begin
      if (is_space(c)) begin
        trailing_space_next = 1'b1;
      end else begin
        tok_start_next      = pos;
        trailing_space_next = 1'b0;
        if ((c == 8'h22) || (c == 8'h27) || (c == 8'h60)) begin
          mode_next           = M_STRING;
          quote_char_next     = c;
          escape_pending_next = 1'b0;
        end else if (is_digit(c)) begin
          mode_next = M_NUMBER;
        end else if (is_alpha(c) || (c == "_") || (c == "$")) begin
          mode_next = M_IDENT;
        end else begin
          mode_next          = M_OP;
          first_op_char_next = c;
        end
      end
    end

    // The final byte flushes an open token, or reports end of file after trailing whitespace.
    emit_b = item.last_byte && ((mode_next != M_IDLE) || trailing_space_next);
    if (mode_next != M_IDLE) begin
      rec_b = make_rec(kind_of(mode_next), tok_start_next, pos_next, 1'b1);
    end else begin
      rec_b = make_rec(KIND_EOF, pos_next, pos_next, 1'b1);
    end
    rec_a.final_token = !emit_b;

    push.rec0  = emit_a ? rec_a : rec_b;
    push.rec1  = rec_b;
    push.count = step ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      mode           <= M_IDLE;
      quote_char     <= '0;
      escape_pending <= 1'b0;
      first_op_char  <= '0;
      star_seen      <= 1'b0;
      tok_start      <= POS_RESET;
      pos            <= POS_RESET;
      trailing_space <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      quote_char     <= quote_char_next;
      escape_pending <= escape_pending_next;
      first_op_char  <= first_op_char_next;
      star_seen      <= star_seen_next;
      tok_start      <= tok_start_next;
      pos            <= pos_next;
      trailing_space <= trailing_space_next;
    end
  end

endmodule

`default_nettype wire

/* sv/jstb_out_fifo.sv */
// ----------------------------------------------------------------------------
// jstb_out_fifo
// Result queue: takes up to two token words per cycle, delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module jstb_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire jstb_pkg::jstb_push_t push,
  output logic                     has_room,
  output logic                     tok_valid,
  input  wire logic                tok_stall,
  output jstb_pkg::tok_word_t      tok_data
);
  import jstb_pkg::*;

  tok_word_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   level;
  logic                     pop;

  assign tok_valid = (level != '0);
  assign tok_data  = slots[rd_ptr];
  assign pop       = tok_valid && !tok_stall;
  // Room for the worst case of two words, ignoring a pop in the same cycle.
  assign has_room  = (level <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_BITS'(pop);
      level  <= level + (FIFO_PTR_BITS+1)'(push.count) - (FIFO_PTR_BITS+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + FIFO_PTR_BITS'(1)] <= push.rec1;
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JavaScript token boundary unit. Source bytes are
// streamed in through the src channel while a bit-accurate lexer model in the
// bench predicts every token word; each word taken from the tok channel is
// checked field by field against the oldest prediction. Both sides idle and
// stall at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import jstb_pkg::*;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_LINE, LX_BLOCK, LX_PUNCT
  } lex_mode_e;

  typedef enum logic [1:0] {GROWS, ENDS_WITH, ENDS_BEFORE} take_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_word_t src_data = '0;
  logic      tok_valid;
  logic      tok_stall = 1'b0;
  tok_word_t tok_data;

  js_lexer_token_boundary_unit dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

  always #5 clk = ~clk;

  // Lexer model state.
  lex_mode_e              lx_mode;
  logic [7:0]             lx_quote;
  logic                   lx_escape;
  logic [7:0]             lx_first_punct;
  logic                   lx_star;
  logic [OFFSET_BITS-1:0] tok_start_offset;
  logic [LINE_BITS-1:0]   tok_start_line;
  logic [LINE_BITS-1:0]   tok_start_col;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [LINE_BITS-1:0]   cur_line;
  logic [LINE_BITS-1:0]   cur_col;
  logic                   ends_in_space;

  tok_word_t  expected_tokens[$];
  logic [7:0] source_bytes[$];
  int         error_count = 0;

  // Sender and receiver pacing.
  int         burst_left = 0;
  bit         sender_steady = 1'b0;
  bit         receiver_steady = 1'b0;
  int         hold_left = 0;
  logic [15:0] stall_pattern = '0;
  logic [3:0] stall_phase = '0;

  string word_start  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$";
  string word_more   = "abcxyzABCXYZ_$0123456789";
  string number_more = "0123456789.xXeE";
  string punct_set   = ";,(){}[]+-*/<>=!&|?:.%^~#@";
  string pair_set    = "==!=<=>=&&||++--=>";
  string filler_set  = "ab*/ z9";

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
           c == "_" || c == "$";
  endfunction

  function automatic logic [2:0] kind_of(input lex_mode_e m);
    case (m)
      LX_IDENT:          return KIND_IDENT;
      LX_NUMBER:         return KIND_NUMBER;
      LX_STRING:         return KIND_STRING;
      LX_LINE, LX_BLOCK: return KIND_COMMENT;
      default:           return KIND_PUNCT;
    endcase
  endfunction

  function automatic tok_word_t token_word(input logic [2:0] kind);
    tok_word_t w;
    w.token_kind   = kind;
    w.start_offset = tok_start_offset;
    w.end_offset   = cur_offset;
    w.start_line   = tok_start_line;
    w.start_column = tok_start_col;
    w.end_line     = cur_line;
    w.end_column   = cur_col;
    w.final_token  = 1'b0;
    return w;
  endfunction

  task automatic clear_lexer();
    lx_mode          = LX_IDLE;
    lx_quote         = '0;
    lx_escape        = 1'b0;
    lx_first_punct   = '0;
    lx_star          = 1'b0;
    tok_start_offset = '0;
    tok_start_line   = LINE_BITS'(1);
    tok_start_col    = LINE_BITS'(1);
    cur_offset       = '0;
    cur_line         = LINE_BITS'(1);
    cur_col          = LINE_BITS'(1);
    ends_in_space    = 1'b0;
  endtask

  // Position counters saturate rather than wrap.
  task automatic step_position(input logic [7:0] c);
    if (cur_offset != '1) cur_offset++;
    if (c == CH_LF) begin
      if (cur_line != '1) cur_line++;
      cur_col = LINE_BITS'(1);
    end else if (cur_col != '1) begin
      cur_col++;
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic last);
    tok_word_t found[$];
    take_e     take;
    bit        taken;
    taken = 1'b0;
    if (lx_mode != LX_IDLE) begin
      take = GROWS;
      case (lx_mode)
        LX_IDENT: begin
          if (!is_word_char(c)) take = ENDS_BEFORE;
        end
        LX_NUMBER: begin
          if (!(is_digit(c) || c == "." || c == "x" || c == "X" || c == "e" || c == "E"))
            take = ENDS_BEFORE;
        end
        LX_STRING: begin
          if (lx_escape) lx_escape = 1'b0;
          else if (c == CH_BSLASH) lx_escape = 1'b1;
          else if (c == lx_quote) take = ENDS_WITH;
        end
        LX_LINE: begin
          if (c == CH_LF) take = ENDS_BEFORE;
        end
        LX_BLOCK: begin
          if (lx_star && c == "/") take = ENDS_WITH;
          else lx_star = (c == "*");
        end
        default: begin
          // A slash may turn out to open a comment instead of being punctuation.
          if (lx_first_punct == "/" && c == "/") begin
            lx_mode = LX_LINE;
          end else if (lx_first_punct == "/" && c == "*") begin
            lx_mode = LX_BLOCK;
            lx_star = 1'b0;
          end else begin
            case ({lx_first_punct, c})
              "==", "!=", "<=", ">=", "&&", "||", "++", "--", "=>": take = ENDS_WITH;
              default: take = ENDS_BEFORE;
            endcase
          end
        end
      endcase
      if (take == ENDS_BEFORE) begin
        found = {found, token_word(kind_of(lx_mode))};
        lx_mode = LX_IDLE;
      end else begin
        step_position(c);
        taken = 1'b1;
        if (take == ENDS_WITH) begin
          found = {found, token_word(kind_of(lx_mode))};
          lx_mode = LX_IDLE;
        end
      end
    end
    if (!taken) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        step_position(c);
        ends_in_space = 1'b1;
      end else begin
        tok_start_offset = cur_offset;
        tok_start_line   = cur_line;
        tok_start_col    = cur_col;
        ends_in_space    = 1'b0;
        if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BACKTICK) begin
          lx_mode   = LX_STRING;
          lx_quote  = c;
          lx_escape = 1'b0;
        end else if (is_digit(c)) begin
          lx_mode = LX_NUMBER;
        end else if (is_word_char(c)) begin
          lx_mode = LX_IDENT;
        end else begin
          lx_mode        = LX_PUNCT;
          lx_first_punct = c;
        end
        step_position(c);
      end
    end
    if (last) begin
      if (lx_mode != LX_IDLE) begin
        found = {found, token_word(kind_of(lx_mode))};
      end else if (ends_in_space) begin
        tok_start_offset = cur_offset;
        tok_start_line   = cur_line;
        tok_start_col    = cur_col;
        found = {found, token_word(KIND_EOF)};
      end
      clear_lexer();
    end
    if (found.size() > 0) found[found.size() - 1].final_token = 1'b1;
    expected_tokens = {expected_tokens, found};
  endtask

  task automatic flag_error(input string msg);
    if (error_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Sends one byte; unless set steady, the sender works in bursts with idle gaps between them.
  task automatic send_byte(input logic [7:0] c, input logic last);
    src_word_t w;
    int        gap;
    w.char_byte = c;
    w.last_byte = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        src_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    src_valid <= 1'b1;
    src_data  <= w;
    do @(posedge clk); while (src_stall);
    predict_tokens(c, last);
  endtask

  task automatic send_text(input string s, input bit ends_source);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_source && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    source_bytes = {source_bytes, b};
  endtask

  // Appends one mostly well-formed token, whitespace run or noise to the source.
  task automatic add_random_token();
    int         pick;
    int         k;
    logic [7:0] q;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      append_byte(pick_char(word_start));
      repeat ($urandom_range(0, 5)) append_byte(pick_char(word_more));
    end else if (pick < 6) begin
      append_byte(8'("0") + 8'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 5)) append_byte(pick_char(number_more));
    end else if (pick < 8) begin
      case ($urandom_range(0, 2))
        0:       q = CH_DQUOTE;
        1:       q = CH_SQUOTE;
        default: q = CH_BACKTICK;
      endcase
      append_byte(q);
      repeat ($urandom_range(0, 6)) begin
        k = $urandom_range(0, 9);
        if (k < 6) begin
          append_byte(pick_char(word_start));
        end else if (k < 8) begin
          append_byte(CH_BSLASH);
          append_byte(($urandom_range(0, 1) == 0) ? q : 8'($urandom_range(0, 255)));
        end else begin
          append_byte(8'($urandom_range(32, 126)));
        end
      end
      if ($urandom_range(0, 6) != 0) append_byte(q);
    end else if (pick == 8) begin
      append_byte("/");
      append_byte("/");
      repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 4) != 0) append_byte(CH_LF);
    end else if (pick == 9) begin
      append_byte("/");
      append_byte("*");
      repeat ($urandom_range(0, 6)) append_byte(pick_char(filler_set));
      if ($urandom_range(0, 4) != 0) begin
        append_byte("*");
        append_byte("/");
      end
    end else if (pick < 12) begin
      k = 2 * $urandom_range(0, 8);
      append_byte(pair_set[k]);
      append_byte(pair_set[k + 1]);
    end else if (pick < 14) begin
      append_byte(pick_char(punct_set));
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 3)) append_byte(pick_space());
    end else begin
      repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Every token kind and the corner cases of quoting and comments.
  task automatic test_token_kinds();
    send_text("id_$9 3.5e1;'x\\'y'//c\n/*/*/==/x", 1'b0);
    send_byte(CH_BACKTICK, 1'b0);
    send_byte("a", 1'b0);
    send_byte(CH_BACKTICK, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(" \n", 1'b1);
  endtask

  // Sources that end inside a token or consist of whitespace only.
  task automatic test_source_edges();
    send_text(" \t", 1'b1);
    send_text("'ab", 1'b1);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b1);
    send_text("a/", 1'b1);
    send_text("/*", 1'b1);
  endtask

  // The receiver holds off long enough for the result queue to fill and the
  // input to stall, while the sender keeps offering bytes back to back.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_left = 80;
    send_text("a+b+c+d+e+f+g+h+i+j+k+l+m+n+o+p+q+r+s+t", 1'b1);
    sender_steady = 1'b0;
  endtask

  task automatic test_random_sources();
    int sent;
    int goal;
    bit quiet;
    sent = 0;
    while (sent < 850) begin
      source_bytes.delete();
      goal = ($urandom_range(0, 14) == 0) ? 150 : $urandom_range(1, 40);
      while (source_bytes.size() < goal) add_random_token();
      quiet = ($urandom_range(0, 4) == 0);
      sender_steady   = quiet;
      receiver_steady = quiet;
      foreach (source_bytes[i]) send_byte(source_bytes[i], i == source_bytes.size() - 1);
      sent += source_bytes.size();
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // Receiver stall: a long hold-off when requested, otherwise a random pattern.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      tok_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (receiver_steady || rst) begin
      tok_stall <= 1'b0;
    end else begin
      tok_stall   <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase == 4'd15) begin
        stall_pattern <= ($urandom_range(0, 1) == 0) ? 16'($urandom & $urandom)
                                                     : 16'($urandom);
      end
    end
  end

  // Each word taken from the block is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && tok_valid === 1'b1 && tok_stall == 1'b0) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("unexpected word, kind %0d at offset %0d",
                             tok_data.token_kind, tok_data.start_offset));
      end else begin
        tok_word_t want;
        want = expected_tokens.pop_front();
        check_field("token_kind", 32'(tok_data.token_kind), 32'(want.token_kind));
        check_field("start_offset", tok_data.start_offset, want.start_offset);
        check_field("end_offset", tok_data.end_offset, want.end_offset);
        check_field("start_line", 32'(tok_data.start_line), 32'(want.start_line));
        check_field("start_column", 32'(tok_data.start_column), 32'(want.start_column));
        check_field("end_line", 32'(tok_data.end_line), 32'(want.end_line));
        check_field("end_column", 32'(tok_data.end_column), 32'(want.end_column));
        check_field("final_token", 32'(tok_data.final_token), 32'(want.final_token));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clear_lexer();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_token_kinds();
    test_source_edges();
    test_backpressure();
    test_random_sources();
    @(negedge clk);
    src_valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_tokens.size() != 0; i++) @(posedge clk);
    if (expected_tokens.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", expected_tokens.size()));
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
